// ===== sv/vector_field_max_difference_defines.svh =====
// Assertion macros for the vector field max difference block.
// Included by the modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef VECTOR_FIELD_MAX_DIFFERENCE_DEFINES_SVH
`define VECTOR_FIELD_MAX_DIFFERENCE_DEFINES_SVH

// Plain property, clocked on clk_i, off while in reset.
`define VFMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define VFMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `VFMD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== sv/vfmd_pkg.sv =====
// Shared types, constants and helpers for the vector field max difference block.
// No dependencies; used by vfmd_sqdiff and vector_field_max_difference.
package vfmd_pkg;

  localparam int unsigned COMP_W      = 16;          // Q11.4 component
  localparam int unsigned MAG_W       = COMP_W + 1;  // component difference
  localparam int unsigned SQ_W        = 34;          // Q26.8 squared length
  localparam int unsigned NUM_COMP    = 3;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned LIN_OUT_W   = 30;
  localparam int unsigned MAX_DIM_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_X = 2'd0,
    CFG_DIM_Y = 2'd1,
    CFG_DIM_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COMP_W-1:0] first_x;
    logic signed [COMP_W-1:0] first_y;
    logic signed [COMP_W-1:0] first_z;
    logic signed [COMP_W-1:0] second_x;
    logic signed [COMP_W-1:0] second_y;
    logic signed [COMP_W-1:0] second_z;
  } in_t;

  typedef struct packed {
    logic        [SQ_W-1:0]      max_sq_length;
    logic        [POS_W-1:0]     pos_x;
    logic        [POS_W-1:0]     pos_y;
    logic        [POS_W-1:0]     pos_z;
    logic        [LIN_OUT_W-1:0] pos_linear;
    logic signed [COMP_W-1:0]    best_first_x;
    logic signed [COMP_W-1:0]    best_first_y;
    logic signed [COMP_W-1:0]    best_first_z;
    logic signed [COMP_W-1:0]    best_second_x;
    logic signed [COMP_W-1:0]    best_second_y;
    logic signed [COMP_W-1:0]    best_second_z;
  } out_t;

  // zero counts as one, anything above the build limit saturates
  function automatic logic [31:0] eff_dim(logic [CFG_W-1:0] raw, logic [31:0] max_dim);
    logic [31:0] wide;
    wide = 32'(raw);
    if (wide == 32'd0) begin
      return 32'd1;
    end else if (wide > max_dim) begin
      return max_dim;
    end
    return wide;
  endfunction

endpackage

// ===== sv/vfmd_sqdiff.sv =====
// Per-component difference and square for one voxel pair.
// Depends on vfmd_pkg; instantiated by vector_field_max_difference.
module vfmd_sqdiff (
  input  vfmd_pkg::in_t                             pair_i,
  output logic [vfmd_pkg::NUM_COMP-1:0][vfmd_pkg::SQ_W-1:0] sq_o
);

  logic signed [vfmd_pkg::NUM_COMP-1:0][vfmd_pkg::COMP_W-1:0] a;
  logic signed [vfmd_pkg::NUM_COMP-1:0][vfmd_pkg::COMP_W-1:0] b;

  assign a[0] = pair_i.first_x;
  assign a[1] = pair_i.first_y;
  assign a[2] = pair_i.first_z;
  assign b[0] = pair_i.second_x;
  assign b[1] = pair_i.second_y;
  assign b[2] = pair_i.second_z;

  always_comb begin
    logic signed [vfmd_pkg::MAG_W-1:0]   diff;
    logic        [vfmd_pkg::MAG_W-1:0]   mag;
    logic        [2*vfmd_pkg::MAG_W-1:0] prod;
    for (int i = 0; i < vfmd_pkg::NUM_COMP; i++) begin
      diff = vfmd_pkg::MAG_W'(signed'(b[i])) - vfmd_pkg::MAG_W'(signed'(a[i]));
      // magnitude of the most negative difference still fits unsigned
      mag  = diff[vfmd_pkg::MAG_W-1] ? vfmd_pkg::MAG_W'(-diff) : vfmd_pkg::MAG_W'(diff);
      prod = mag * mag;
      sq_o[i] = vfmd_pkg::SQ_W'(prod);
    end
  end

endmodule

// ===== sv/vector_field_max_difference.sv =====
// Top level: streaming argmax of squared difference length between two vector fields.
// Depends on vfmd_pkg, vfmd_sqdiff and vector_field_max_difference_defines.svh.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | in_valid_i / in_stall_o / in_data_i  | in
//   output   | out_valid_o / out_stall_i / out_data_o | out
//   config   | cfg_we_i / cfg_idx_i / cfg_data_i    | in
//
// One voxel beat per cycle sustained while the result is not stalled; the last voxel of a
// volume passes through the input register and the squaring register, then
// compare-and-update loads the result register.
// The compare of the summed squares against the running maximum and the voxel counters are the only feedback.
// Reset clears counters, running maximum and dims (all dims 1); no clearing pass.
// A stalled result holds the last voxel of the next volume at the compare stage; the
// beats behind it back up and the input stalls once both earlier registers are full.
`include "vector_field_max_difference_defines.svh"

module vector_field_max_difference #(
  parameter int unsigned MAX_DIM = vfmd_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vfmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vfmd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  vfmd_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output vfmd_pkg::out_t                 out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned LIN_W = 3 * CNT_W;

  // pipeline valids
  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_rdy, s2_rdy, in_fire, acc_fire, acc_last;

  vfmd_pkg::in_t in_q, pair_q, best_vec_q;
  logic [vfmd_pkg::NUM_COMP-1:0][vfmd_pkg::SQ_W-1:0] sq_d, sq_q;

  logic [DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;
  logic [CNT_W-1:0] cnt_x_q, cnt_y_q, cnt_z_q, cnt_x_d, cnt_y_d, cnt_z_d;
  logic [LIN_W-1:0] cnt_lin_q, cnt_lin_d;
  logic [CNT_W-1:0] best_x_q, best_y_q, best_z_q, best_x_d, best_y_d, best_z_d;
  logic [LIN_W-1:0] best_lin_q, best_lin_d;
  logic [vfmd_pkg::SQ_W-1:0] best_sq_q, best_sq_d, sum_sq;
  vfmd_pkg::in_t    best_vec_d;
  vfmd_pkg::out_t   out_q, out_d;
  logic last_x, last_y, last_z, gt, take, cfg_clear;

  // ---------------- handshake ----------------
  assign acc_fire   = s2_v_q & (~acc_last | ~out_v_q | ~out_stall_i);
  assign s2_rdy     = ~s2_v_q | acc_fire;
  assign s1_rdy     = ~s1_v_q | s2_rdy;
  assign in_fire    = in_valid_i & s1_rdy;
  assign in_stall_o = ~s1_rdy;

  // ---------------- config ----------------
  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      unique case (vfmd_pkg::cfg_reg_e'(cfg_idx_i))
        vfmd_pkg::CFG_DIM_X,
        vfmd_pkg::CFG_DIM_Y,
        vfmd_pkg::CFG_DIM_Z: cfg_clear = 1'b1;
        default:             cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DIM_W'(1);
      dim_y_q <= DIM_W'(1);
      dim_z_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (vfmd_pkg::cfg_reg_e'(cfg_idx_i))
        vfmd_pkg::CFG_DIM_X: dim_x_q <= DIM_W'(vfmd_pkg::eff_dim(cfg_data_i, 32'(MAX_DIM)));
        vfmd_pkg::CFG_DIM_Y: dim_y_q <= DIM_W'(vfmd_pkg::eff_dim(cfg_data_i, 32'(MAX_DIM)));
        vfmd_pkg::CFG_DIM_Z: dim_z_q <= DIM_W'(vfmd_pkg::eff_dim(cfg_data_i, 32'(MAX_DIM)));
        default: ;
      endcase
    end
  end

  // ---------------- stage 1 / 2 ----------------
  vfmd_sqdiff u_sqdiff (
    .pair_i (in_q),
    .sq_o   (sq_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_data_i;
    if (s2_rdy && s1_v_q) begin
      pair_q <= in_q;
      sq_q   <= sq_d;
    end
  end

  // ---------------- accumulate stage ----------------
  assign sum_sq = sq_q[0] + sq_q[1] + sq_q[2];
  assign last_x = (DIM_W'(cnt_x_q) + DIM_W'(1)) >= dim_x_q;
  assign last_y = (DIM_W'(cnt_y_q) + DIM_W'(1)) >= dim_y_q;
  assign last_z = (DIM_W'(cnt_z_q) + DIM_W'(1)) >= dim_z_q;
  assign acc_last = last_x & last_y & last_z;

  always_comb begin
    gt   = sum_sq > best_sq_q;
    // first voxel of a volume always seeds the stored vectors
    take = gt | (cnt_lin_q == '0);

    best_sq_d  = gt ? sum_sq : best_sq_q;
    best_x_d   = take ? cnt_x_q   : best_x_q;
    best_y_d   = take ? cnt_y_q   : best_y_q;
    best_z_d   = take ? cnt_z_q   : best_z_q;
    best_lin_d = take ? cnt_lin_q : best_lin_q;
    best_vec_d = take ? pair_q    : best_vec_q;

    cnt_lin_d = cnt_lin_q + LIN_W'(1);
    cnt_x_d   = cnt_x_q;
    cnt_y_d   = cnt_y_q;
    cnt_z_d   = cnt_z_q;
    if (!last_x) begin
      cnt_x_d = cnt_x_q + CNT_W'(1);
    end else begin
      cnt_x_d = '0;
      if (!last_y) begin
        cnt_y_d = cnt_y_q + CNT_W'(1);
      end else begin
        cnt_y_d = '0;
        cnt_z_d = cnt_z_q + CNT_W'(1);
      end
    end

    out_d.max_sq_length = best_sq_d;
    out_d.pos_x         = vfmd_pkg::POS_W'(best_x_d);
    out_d.pos_y         = vfmd_pkg::POS_W'(best_y_d);
    out_d.pos_z         = vfmd_pkg::POS_W'(best_z_d);
    out_d.pos_linear    = vfmd_pkg::LIN_OUT_W'(best_lin_d);
    out_d.best_first_x  = best_vec_d.first_x;
    out_d.best_first_y  = best_vec_d.first_y;
    out_d.best_first_z  = best_vec_d.first_z;
    out_d.best_second_x = best_vec_d.second_x;
    out_d.best_second_y = best_vec_d.second_y;
    out_d.best_second_z = best_vec_d.second_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_sq_q <= '0;
      cnt_x_q   <= '0;
      cnt_y_q   <= '0;
      cnt_z_q   <= '0;
      cnt_lin_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (cfg_clear || (acc_fire && acc_last)) begin
        best_sq_q <= '0;
        cnt_x_q   <= '0;
        cnt_y_q   <= '0;
        cnt_z_q   <= '0;
        cnt_lin_q <= '0;
      end else if (acc_fire) begin
        best_sq_q <= best_sq_d;
        cnt_x_q   <= cnt_x_d;
        cnt_y_q   <= cnt_y_d;
        cnt_z_q   <= cnt_z_d;
        cnt_lin_q <= cnt_lin_d;
      end
      if (acc_fire && acc_last) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire) begin
      best_x_q   <= best_x_d;
      best_y_q   <= best_y_d;
      best_z_q   <= best_z_d;
      best_lin_q <= best_lin_d;
      best_vec_q <= best_vec_d;
    end
    if (acc_fire && acc_last) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------- checks ----------------
  `VFMD_ASSERT(a_cnt_in_range,
    (DIM_W'(cnt_x_q) < dim_x_q) && (DIM_W'(cnt_y_q) < dim_y_q) && (DIM_W'(cnt_z_q) < dim_z_q),
    "voxel counter ran past its dimension")
  `VFMD_ASSERT_NEXT(a_last_gives_result, acc_fire && acc_last, out_v_q,
    "last voxel did not load a result")
  `VFMD_ASSERT_NEXT(a_volume_restarts, acc_fire && acc_last, cnt_lin_q == '0,
    "counters not cleared after a volume")
  `VFMD_ASSERT_NEXT(a_max_monotonic, acc_fire && !acc_last && !cfg_clear,
    best_sq_q >= $past(best_sq_q), "running maximum decreased")

endmodule
